// ===== hw/rtl/keep_awake_pause_policy_top_assert.svh =====
// Assertion macros for the keep-awake pause policy checker.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef KEEP_AWAKE_PAUSE_POLICY_TOP_ASSERT_SVH
`define KEEP_AWAKE_PAUSE_POLICY_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside of reset.
`define KAPP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KAPP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kapp_pkg.sv =====
// Shared types and codes for the keep-awake pause policy block.
// No dependencies; used by kapp_decide, the top level and the checker.
package kapp_pkg;

   localparam logic [10:0] MINUTES_PER_DAY = 11'(24 * 60);

   localparam int CSR_DATA_W = 22;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BATT_THR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_START   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_END     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DURATION   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_COOLDOWN   = 3'd5;

   localparam logic [6:0]  ENABLE_MASK_RST  = 7'd15;
   localparam logic [6:0]  LOW_BATT_THR_RST = 7'd20;
   localparam logic [16:0] COOLDOWN_RST     = 17'd60;

   localparam int EN_ACTIVITY = 0;
   localparam int EN_LOCKED   = 1;
   localparam int EN_DISCONN  = 2;
   localparam int EN_LOWBATT  = 3;
   localparam int EN_ONBATT   = 4;
   localparam int EN_FULLSCR  = 5;
   localparam int EN_HOURS    = 6;

   typedef enum logic [1:0] {
      MODE_EVAL  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACT_RUN   = 2'd0,
      ACT_PAUSE = 2'd1,
      ACT_STOP  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_RUNNING = 2'd1,
      ST_PAUSED  = 2'd2
   } run_state_type;

   typedef enum logic [3:0] {
      R_NONE     = 4'd0,
      R_MANUAL   = 4'd1,
      R_ACTIVITY = 4'd2,
      R_LOCKED   = 4'd3,
      R_DISCONN  = 4'd4,
      R_LOWBATT  = 4'd5,
      R_ONBATT   = 4'd6,
      R_FULLSCR  = 4'd7,
      R_HOURS    = 4'd8,
      R_MAXDUR   = 4'd9
   } reason_type;

   typedef struct packed {
      logic [6:0]  enable_mask;
      logic [6:0]  low_batt_thr;
      logic [10:0] active_start_minute;
      logic [10:0] active_end_minute;
      logic [21:0] run_limit;
      logic [16:0] activity_cooldown;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_seconds;
      logic        user_input;
      logic        locked;
      logic        disconnected;
      logic        on_batt;
      logic [6:0]  batt_level;
      logic        fullscreen;
      logic [10:0] day_minute;
   } req_type;

   typedef struct packed {
      run_state_type run_state;
      reason_type    last_reason;
      logic [31:0]   start_time;
      logic [31:0]   last_activity_time;
      logic          activity_seen;
   } ctx_type;

   typedef struct packed {
      action_type    action;
      run_state_type engine_state;
      reason_type    reason;
      logic [16:0]   cool_secs;
   } rsp_type;

endpackage

// ===== hw/rtl/kapp_decide.sv =====
// Policy decision for one item: next engine context and the result.
// Depends on kapp_pkg.
module kapp_decide (
   input  kapp_pkg::cfg_type cfg,
   input  kapp_pkg::req_type req,
   input  kapp_pkg::ctx_type ctx,
   output kapp_pkg::ctx_type ctx_next,
   output kapp_pkg::rsp_type rsp,
   output logic              has_rsp
);

   logic        act_rec;
   logic [31:0] last_act;
   logic        seen;
   logic [31:0] run_elapsed;
   logic [31:0] act_elapsed;
   logic        maxdur_hit;
   logic        cool_hit;
   logic [16:0] cool_left;
   logic        in_window;
   logic        lowbatt_hit;

   assign act_rec  = req.user_input && cfg.enable_mask[kapp_pkg::EN_ACTIVITY];
   assign last_act = act_rec ? req.now_seconds : ctx.last_activity_time;
   assign seen     = act_rec || ctx.activity_seen;

   assign run_elapsed = (req.now_seconds >= ctx.start_time) ?
                        (req.now_seconds - ctx.start_time) : 32'd0;
   assign act_elapsed = (req.now_seconds >= last_act) ?
                        (req.now_seconds - last_act) : 32'd0;

   assign maxdur_hit = (cfg.run_limit != 22'd0) &&
                       (run_elapsed >= {10'd0, cfg.run_limit});
   assign cool_hit   = cfg.enable_mask[kapp_pkg::EN_ACTIVITY] && seen &&
                       (act_elapsed < {15'd0, cfg.activity_cooldown});
   assign cool_left  = cfg.activity_cooldown - act_elapsed[16:0];

   assign lowbatt_hit = req.on_batt &&
                        (req.batt_level <= cfg.low_batt_thr);

   always_comb begin
      if (req.day_minute >= kapp_pkg::MINUTES_PER_DAY) begin
         in_window = 1'b0;
      end else if (cfg.active_start_minute < cfg.active_end_minute) begin
         in_window = (req.day_minute >= cfg.active_start_minute) &&
                     (req.day_minute < cfg.active_end_minute);
      end else if (cfg.active_start_minute > cfg.active_end_minute) begin
         in_window = (req.day_minute >= cfg.active_start_minute) ||
                     (req.day_minute < cfg.active_end_minute);
      end else begin
         in_window = 1'b1;
      end
   end

   always_comb begin
      kapp_pkg::run_state_type st;
      kapp_pkg::reason_type    why;
      logic [16:0]             cool;

      ctx_next = ctx;
      has_rsp  = 1'b0;
      rsp.action       = kapp_pkg::ACT_STOP;
      rsp.engine_state = kapp_pkg::ST_STOPPED;
      rsp.reason       = ctx.last_reason;
      rsp.cool_secs    = 17'd0;
      st   = kapp_pkg::ST_RUNNING;
      why  = kapp_pkg::R_NONE;
      cool = 17'd0;

      case (req.mode)
         kapp_pkg::MODE_START: begin
            ctx_next.run_state          = kapp_pkg::ST_RUNNING;
            ctx_next.last_reason        = kapp_pkg::R_NONE;
            ctx_next.start_time         = req.now_seconds;
            ctx_next.last_activity_time = 32'd0;
            ctx_next.activity_seen      = 1'b0;
         end
         kapp_pkg::MODE_STOP: begin
            ctx_next.run_state   = kapp_pkg::ST_STOPPED;
            ctx_next.last_reason = kapp_pkg::R_MANUAL;
         end
         kapp_pkg::MODE_EVAL: begin
            has_rsp = 1'b1;
            if (ctx.run_state != kapp_pkg::ST_STOPPED) begin
               ctx_next.last_activity_time = last_act;
               ctx_next.activity_seen      = seen;
               if (maxdur_hit) begin
                  st  = kapp_pkg::ST_STOPPED;
                  why = kapp_pkg::R_MAXDUR;
               end else if (cfg.enable_mask[kapp_pkg::EN_LOCKED] && req.locked) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_LOCKED;
               end else if (cfg.enable_mask[kapp_pkg::EN_DISCONN] && req.disconnected) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_DISCONN;
               end else if (cfg.enable_mask[kapp_pkg::EN_LOWBATT] && lowbatt_hit) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_LOWBATT;
               end else if (cfg.enable_mask[kapp_pkg::EN_ONBATT] && req.on_batt) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_ONBATT;
               end else if (cfg.enable_mask[kapp_pkg::EN_FULLSCR] && req.fullscreen) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_FULLSCR;
               end else if (cfg.enable_mask[kapp_pkg::EN_HOURS] && !in_window) begin
                  st  = kapp_pkg::ST_PAUSED;
                  why = kapp_pkg::R_HOURS;
               end else if (cool_hit) begin
                  st   = kapp_pkg::ST_PAUSED;
                  why  = kapp_pkg::R_ACTIVITY;
                  cool = cool_left;
               end
               ctx_next.run_state   = st;
               ctx_next.last_reason = why;
               rsp.engine_state     = st;
               rsp.reason           = why;
               case (st)
                  kapp_pkg::ST_STOPPED: begin
                     rsp.action = kapp_pkg::ACT_STOP;
                  end
                  kapp_pkg::ST_PAUSED: begin
                     rsp.action    = kapp_pkg::ACT_PAUSE;
                     rsp.cool_secs = cool;
                  end
                  default: begin
                     rsp.action = kapp_pkg::ACT_RUN;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/keep_awake_pause_policy_top.sv =====
// Keep-awake pause policy engine: input register, decision logic, result register.
// An accepted item is held in the input register, and its result is then captured in the result register.
// Throughput: one item per cycle unless an evaluate item waits on a stalled result, which holds the input stage only.
// Start and stop items never wait on a stalled result and give no result.
// Synchronous reset restores register defaults and a stopped engine, reason none.
// Depends on kapp_pkg and kapp_decide.
module keep_awake_pause_policy_top (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            csr_we,
   input  logic [kapp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kapp_pkg::CSR_DATA_W-1:0] csr_wdata,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic [31:0]                     req_now_seconds,
   input  logic                            req_user_input,
   input  logic                            req_locked,
   input  logic                            req_disconnected,
   input  logic                            req_on_batt,
   input  logic [6:0]                      req_batt_level,
   input  logic                            req_fullscreen,
   input  logic [10:0]                     req_day_minute,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_action,
   output logic [1:0]                      rsp_engine_state_out,
   output logic [3:0]                      rsp_reason_code,
   output logic [16:0]                     rsp_cool_secs
);

   kapp_pkg::cfg_type cfg_ff, cfg_in;
   kapp_pkg::req_type req_ff, req_in;
   logic              req_valid_ff, req_valid_in;
   kapp_pkg::ctx_type ctx_ff, ctx_in;
   kapp_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   kapp_pkg::ctx_type ctx_next;
   kapp_pkg::rsp_type rsp_next;
   logic              has_rsp;
   logic              advance;

   kapp_decide u_decide (
      .cfg      (cfg_ff),
      .req      (req_ff),
      .ctx      (ctx_ff),
      .ctx_next (ctx_next),
      .rsp      (rsp_next),
      .has_rsp  (has_rsp)
   );

   assign advance   = req_valid_ff && (!has_rsp || !rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kapp_pkg::CSR_ENABLE_MASK:  cfg_in.enable_mask         = csr_wdata[6:0];
            kapp_pkg::CSR_LOW_BATT_THR: cfg_in.low_batt_thr        = csr_wdata[6:0];
            kapp_pkg::CSR_ACTIVE_START: cfg_in.active_start_minute = csr_wdata[10:0];
            kapp_pkg::CSR_ACTIVE_END:   cfg_in.active_end_minute   = csr_wdata[10:0];
            kapp_pkg::CSR_MAX_DURATION: cfg_in.run_limit           = csr_wdata[21:0];
            kapp_pkg::CSR_ACT_COOLDOWN: cfg_in.activity_cooldown   = csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_ready ? req_valid : req_valid_ff;
      req_in       = req_ff;
      if (req_valid && req_ready) begin
         req_in.mode         = req_mode;
         req_in.now_seconds  = req_now_seconds;
         req_in.user_input   = req_user_input;
         req_in.locked       = req_locked;
         req_in.disconnected = req_disconnected;
         req_in.on_batt      = req_on_batt;
         req_in.batt_level   = req_batt_level;
         req_in.fullscreen   = req_fullscreen;
         req_in.day_minute   = req_day_minute;
      end
   end

   always_comb begin
      ctx_in       = advance ? ctx_next : ctx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_rsp) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask           <= kapp_pkg::ENABLE_MASK_RST;
         cfg_ff.low_batt_thr          <= kapp_pkg::LOW_BATT_THR_RST;
         cfg_ff.active_start_minute   <= 11'd0;
         cfg_ff.active_end_minute     <= 11'd0;
         cfg_ff.run_limit             <= 22'd0;
         cfg_ff.activity_cooldown     <= kapp_pkg::COOLDOWN_RST;
         ctx_ff.run_state             <= kapp_pkg::ST_STOPPED;
         ctx_ff.last_reason           <= kapp_pkg::R_NONE;
         ctx_ff.start_time            <= 32'd0;
         ctx_ff.last_activity_time    <= 32'd0;
         ctx_ff.activity_seen         <= 1'b0;
         req_valid_ff                 <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         ctx_ff       <= ctx_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = rsp_ff.action;
   assign rsp_engine_state_out = rsp_ff.engine_state;
   assign rsp_reason_code      = rsp_ff.reason;
   assign rsp_cool_secs        = rsp_ff.cool_secs;

endmodule

// ===== hw/rtl/kapp_checker.sv =====
// Port-level checks for the keep-awake pause policy top level, attached by bind.
// Depends on kapp_pkg and keep_awake_pause_policy_top_assert.svh.
`include "keep_awake_pause_policy_top_assert.svh"

module kapp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_action,
   input logic [1:0]  rsp_engine_state_out,
   input logic [3:0]  rsp_reason_code,
   input logic [16:0] rsp_cool_secs
);

   `KAPP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_action) && $stable(rsp_reason_code) && $stable(rsp_cool_secs), "stalled item changed")

   `KAPP_ASSERT_IMP(a_run_clean, rsp_valid && rsp_action == kapp_pkg::ACT_RUN, rsp_engine_state_out == kapp_pkg::ST_RUNNING && rsp_reason_code == kapp_pkg::R_NONE && rsp_cool_secs == 17'd0, "run item with stray fields")

   `KAPP_ASSERT_IMP(a_stop_state, rsp_valid && rsp_action == kapp_pkg::ACT_STOP, rsp_engine_state_out == kapp_pkg::ST_STOPPED && rsp_cool_secs == 17'd0, "stop item not stopped")

   `KAPP_ASSERT_IMP(a_cool_only, rsp_valid && rsp_cool_secs != 17'd0, rsp_action == kapp_pkg::ACT_PAUSE && rsp_reason_code == kapp_pkg::R_ACTIVITY, "cooldown outside activity pause")

endmodule

bind keep_awake_pause_policy_top kapp_checker u_kapp_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_action           (rsp_action),
   .rsp_engine_state_out (rsp_engine_state_out),
   .rsp_reason_code      (rsp_reason_code),
   .rsp_cool_secs        (rsp_cool_secs)
);
